### sv/ssnf_pkg.sv
// ----------------------------------------------------------------------------
// ssnf_pkg
// Shared types, constants and lookup functions for the seven-segment
// number formatter.
// ----------------------------------------------------------------------------
package ssnf_pkg;

    localparam int READ_W        = 64;
    localparam int INT_W         = 40;   // holds 10^12 - 1
    localparam int FRAC_W        = 20;   // holds 10^6
    localparam int CELL_W        = 5;
    localparam int SEG_W         = 7;
    localparam int NDIG_W        = 4;
    localparam int FDIG_W        = 3;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 4;
    localparam int QUEUE_DEPTH   = 4;

    localparam int DEF_MAX_INTEGER_DIGITS  = 12;
    localparam int DEF_MAX_FRACTION_DIGITS = 6;
    localparam int DEF_FRACTION_BITS       = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_INTEGER_DIGITS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRACTION_DIGITS = 2'd1;

    localparam logic [SEG_W-1:0] SEG_DASH  = 7'h40;
    localparam logic [SEG_W-1:0] SEG_BLANK = 7'h00;

    // One classified reading, handed from front to back
    typedef struct packed {
        logic              has_reading;
        logic              neg;
        logic              ovl;
        logic [INT_W-1:0]  whole_part;
        logic [FRAC_W-1:0] frac_part;
        logic [NDIG_W-1:0] n_int;
        logic [FDIG_W-1:0] n_frac;
    } ssnf_item_t;

    function automatic logic [INT_W-1:0] pow10(input logic [NDIG_W-1:0] p);
        logic [INT_W-1:0] r;
        unique case (p)
            4'd0:    r = 40'd1;
            4'd1:    r = 40'd10;
            4'd2:    r = 40'd100;
            4'd3:    r = 40'd1000;
            4'd4:    r = 40'd10000;
            4'd5:    r = 40'd100000;
            4'd6:    r = 40'd1000000;
            4'd7:    r = 40'd10000000;
            4'd8:    r = 40'd100000000;
            4'd9:    r = 40'd1000000000;
            4'd10:   r = 40'd10000000000;
            4'd11:   r = 40'd100000000000;
            4'd12:   r = 40'd1000000000000;
            default: r = 40'd0;
        endcase
        return r;
    endfunction

    function automatic logic [SEG_W-1:0] digit_mask(input logic [3:0] d);
        logic [SEG_W-1:0] m;
        unique case (d)
            4'd0:    m = 7'h3F;
            4'd1:    m = 7'h06;
            4'd2:    m = 7'h5B;
            4'd3:    m = 7'h4F;
            4'd4:    m = 7'h66;
            4'd5:    m = 7'h6D;
            4'd6:    m = 7'h7D;
            4'd7:    m = 7'h07;
            4'd8:    m = 7'h7F;
            4'd9:    m = 7'h6F;
            default: m = SEG_BLANK;
        endcase
        return m;
    endfunction

endpackage

### sv/ssnf_front.sv
// ----------------------------------------------------------------------------
// ssnf_front
// Accepts readings, takes the magnitude, rounds the fraction to the
// configured resolution and classifies overload, over three stages.
// ----------------------------------------------------------------------------
module ssnf_front #(
    parameter int MAX_INTEGER_DIGITS  = ssnf_pkg::DEF_MAX_INTEGER_DIGITS,
    parameter int MAX_FRACTION_DIGITS = ssnf_pkg::DEF_MAX_FRACTION_DIGITS,
    parameter int FRACTION_BITS       = ssnf_pkg::DEF_FRACTION_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              take,
    input  logic [ssnf_pkg::READ_W-1:0]       reading,
    input  logic                              reading_valid,
    input  logic [ssnf_pkg::NDIG_W-1:0]       cfg_int,
    input  logic [ssnf_pkg::FDIG_W-1:0]       cfg_frac,
    input  logic                              pop,
    output logic                              full,
    output logic                              push,
    output ssnf_pkg::ssnf_item_t              push_item
);
    import ssnf_pkg::*;

    localparam int HI_W   = READ_W - FRACTION_BITS;
    localparam int PROD_W = FRACTION_BITS + FRAC_W;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PROD_W:0] HALF =
        {{(FRAC_W + 1){1'b0}}, 1'b1, {(FRACTION_BITS - 1){1'b0}}};

    // stage A
    logic                     a_vld_reg;
    logic [HI_W-1:0]          a_hi_reg;
    logic [FRACTION_BITS-1:0] a_lo_reg;
    logic                     a_neg_reg, a_rd_reg;
    logic [NDIG_W-1:0]        a_n_reg;
    logic [FDIG_W-1:0]        a_f_reg;
    // stage B
    logic                     b_vld_reg;
    logic [HI_W-1:0]          b_hi_reg;
    logic [PROD_W-1:0]        b_prod_reg;
    logic                     b_neg_reg, b_rd_reg;
    logic [NDIG_W-1:0]        b_n_reg;
    logic [FDIG_W-1:0]        b_f_reg;

    logic [CNT_W-1:0]         inflight_reg, inflight_next;
    logic [READ_W-1:0]        mag;
    logic [NDIG_W-1:0]        n_clamp;
    logic [FDIG_W-1:0]        f_clamp;
    logic [INT_W-1:0]         pow_a_full, pow_b_full;
    logic [FRAC_W-1:0]        pow_a, pow_b;
    logic [PROD_W:0]          rsum;
    logic [FRAC_W:0]          t;
    logic                     carry;
    logic [HI_W:0]            int_full;
    logic [HI_W:0]            limit;

    // Clamp the digit counts into range
    always_comb
    begin
        if (cfg_int == '0)
            n_clamp = NDIG_W'(1);
        else if (cfg_int > NDIG_W'(MAX_INTEGER_DIGITS))
            n_clamp = NDIG_W'(MAX_INTEGER_DIGITS);
        else
            n_clamp = cfg_int;
        if (cfg_frac > FDIG_W'(MAX_FRACTION_DIGITS))
            f_clamp = FDIG_W'(MAX_FRACTION_DIGITS);
        else
            f_clamp = cfg_frac;
        mag = reading[READ_W-1] ? (~reading + READ_W'(1)) : reading;
    end

    // Stage A: split magnitude
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else
            a_vld_reg <= take;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            a_hi_reg  <= mag[READ_W-1:FRACTION_BITS];
            a_lo_reg  <= mag[FRACTION_BITS-1:0];
            a_neg_reg <= reading_valid & reading[READ_W-1];
            a_rd_reg  <= reading_valid;
            a_n_reg   <= n_clamp;
            a_f_reg   <= f_clamp;
        end
    end

    // Stage B: scale fraction by 10^f
    assign pow_a_full = pow10(NDIG_W'(a_f_reg));
    assign pow_a      = pow_a_full[FRAC_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_vld_reg <= 1'b0;
        else
            b_vld_reg <= a_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (a_vld_reg)
        begin
            b_hi_reg   <= a_hi_reg;
            b_prod_reg <= {{FRAC_W{1'b0}}, a_lo_reg} * {{FRACTION_BITS{1'b0}}, pow_a};
            b_neg_reg  <= a_neg_reg;
            b_rd_reg   <= a_rd_reg;
            b_n_reg    <= a_n_reg;
            b_f_reg    <= a_f_reg;
        end
    end

    // Stage C: round half away, carry into integer, test overload
    always_comb
    begin
        pow_b_full = pow10(NDIG_W'(b_f_reg));
        pow_b      = pow_b_full[FRAC_W-1:0];
        rsum       = {1'b0, b_prod_reg} + HALF;
        t          = rsum[PROD_W:FRACTION_BITS];
        carry      = (t == {1'b0, pow_b});
        int_full   = {1'b0, b_hi_reg} + {{HI_W{1'b0}}, carry};
        limit      = {{(HI_W + 1 - INT_W){1'b0}}, pow10(b_n_reg)};

        push                  = b_vld_reg;
        push_item.has_reading = b_rd_reg;
        push_item.neg         = b_neg_reg;
        push_item.ovl         = b_rd_reg && (int_full >= limit);
        push_item.whole_part  = b_rd_reg ? int_full[INT_W-1:0] : '0;
        push_item.frac_part   = (b_rd_reg && !carry) ? t[FRAC_W-1:0] : '0;
        push_item.n_int       = b_n_reg;
        push_item.n_frac      = b_f_reg;
    end

    // Count words between accept and pop; reserves queue space
    always_comb
    begin
        inflight_next = inflight_reg;
        if (take && !pop)
            inflight_next = inflight_reg + CNT_W'(1);
        else if (!take && pop)
            inflight_next = inflight_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else
            inflight_reg <= inflight_next;
    end

    assign full = (inflight_reg == CNT_W'(QUEUE_DEPTH));

endmodule

### sv/ssnf_queue.sv
// ----------------------------------------------------------------------------
// ssnf_queue
// Short first-in first-out queue of classified readings.
// ----------------------------------------------------------------------------
module ssnf_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  ssnf_pkg::ssnf_item_t push_item,
    input  logic                 pop,
    output logic                 empty,
    output ssnf_pkg::ssnf_item_t head
);
    import ssnf_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    ssnf_item_t       mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg, rd_reg;
    logic [CNT_W-1:0] count_reg;

    // Write entry
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_item;
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
            if (pop)
                rd_reg <= (rd_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (!push && pop)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    assign empty = (count_reg == '0);
    assign head  = mem[rd_reg];

endmodule

### sv/ssnf_back.sv
// ----------------------------------------------------------------------------
// ssnf_back
// Walks one row of cells per word, one cell a cycle, pulling decimal
// digits most significant first from a running remainder.
// ----------------------------------------------------------------------------
module ssnf_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          empty,
    input  ssnf_pkg::ssnf_item_t          head,
    output logic                          pop,
    output logic                          result_strobe,
    output logic [ssnf_pkg::SEG_W-1:0]    segments,
    output logic                          point_after,
    output logic [ssnf_pkg::CELL_W-1:0]   cell_number,
    output logic                          overload,
    output logic                          last_cell
);
    import ssnf_pkg::*;

    logic             active_reg, active_next;
    ssnf_item_t       item_reg;
    logic [CELL_W-1:0] cell_reg, cell_next;
    logic [INT_W-1:0] rem_reg, rem_next;
    logic             started_reg, started_next;

    logic [CELL_W-1:0] n5, last_idx, p5;
    logic              int_phase, sign_cell, is_last;
    logic [NDIG_W-1:0] p;
    logic [INT_W-1:0]  base, thr, sub;
    logic [3:0]        digit;
    logic              show;

    always_comb
    begin
        n5        = {1'b0, item_reg.n_int};
        last_idx  = n5 + {2'b0, item_reg.n_frac};
        sign_cell = (cell_reg == '0);
        int_phase = (cell_reg <= n5);
        p5        = int_phase ? (n5 - cell_reg) : (last_idx - cell_reg);
        p         = p5[NDIG_W-1:0];
        is_last   = active_reg && (cell_reg == last_idx);
        base      = pow10(p);

        // Pick the largest digit whose multiple fits the remainder
        digit = 4'd0;
        sub   = '0;
        for (int d = 1; d <= 9; d++)
        begin
            thr = base * INT_W'(d);
            if (rem_reg >= thr)
            begin
                digit = 4'(d);
                sub   = thr;
            end
        end

        show = started_reg || (digit != 4'd0) || (cell_reg == n5);

        // Drive the cell
        result_strobe = active_reg;
        cell_number   = cell_reg;
        overload      = item_reg.ovl;
        last_cell     = is_last;
        point_after   = item_reg.has_reading && (item_reg.n_frac != '0) && (cell_reg == n5);
        if (!item_reg.has_reading)
            segments = SEG_BLANK;
        else if (sign_cell)
            segments = item_reg.neg ? SEG_DASH : SEG_BLANK;
        else if (item_reg.ovl)
            segments = SEG_DASH;
        else if (!int_phase || show)
            segments = digit_mask(digit);
        else
            segments = SEG_BLANK;

        // Advance the row, or load the next word
        pop          = !empty && (!active_reg || is_last);
        active_next  = active_reg;
        cell_next    = cell_reg;
        rem_next     = rem_reg;
        started_next = started_reg;
        if (pop)
        begin
            active_next  = 1'b1;
            cell_next    = '0;
            rem_next     = head.whole_part;
            started_next = 1'b0;
        end
        else if (is_last)
            active_next = 1'b0;
        else if (active_reg)
        begin
            cell_next = cell_reg + CELL_W'(1);
            if (cell_reg == n5)
                rem_next = {{(INT_W - FRAC_W){1'b0}}, item_reg.frac_part};
            else if (!sign_cell)
                rem_next = rem_reg - sub;
            if (!sign_cell && digit != 4'd0)
                started_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_reg <= 1'b0;
        else
            active_reg <= active_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            item_reg <= head;
        cell_reg    <= cell_next;
        rem_reg     <= rem_next;
        started_reg <= started_next;
    end

endmodule

### sv/seven_segment_number_formatter.sv
// ----------------------------------------------------------------------------
// seven_segment_number_formatter
// An accepted word passes stage A, stage B and the queue before its first cell.
// Throughput: one cell per cycle, 1 + integer + fraction cells per word
// (2 to 19 cells), set by the digit-by-digit back end.
// busy rises when four words are in flight; results cannot be stalled.
// Reset: integer_digits 4, fraction_digits 2, all words dropped.
// ----------------------------------------------------------------------------
module seven_segment_number_formatter #(
    parameter int MAX_INTEGER_DIGITS  = ssnf_pkg::DEF_MAX_INTEGER_DIGITS,
    parameter int MAX_FRACTION_DIGITS = ssnf_pkg::DEF_MAX_FRACTION_DIGITS,
    parameter int FRACTION_BITS       = ssnf_pkg::DEF_FRACTION_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [ssnf_pkg::READ_W-1:0]       reading,
    input  logic                              reading_valid,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ssnf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ssnf_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                              result_strobe,
    output logic [ssnf_pkg::SEG_W-1:0]        segments,
    output logic                              point_after,
    output logic [ssnf_pkg::CELL_W-1:0]       cell_number,
    output logic                              overload,
    output logic                              last_cell
);
    import ssnf_pkg::*;

    logic [NDIG_W-1:0] int_digits_reg;
    logic [FDIG_W-1:0] frac_digits_reg;
    logic              take, full, push, pop, empty;
    ssnf_item_t        push_item, head;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            int_digits_reg  <= NDIG_W'(4);
            frac_digits_reg <= FDIG_W'(2);
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_INTEGER_DIGITS)
                int_digits_reg <= cfg_data[NDIG_W-1:0];
            else if (cfg_index == CFG_FRACTION_DIGITS)
                frac_digits_reg <= cfg_data[FDIG_W-1:0];
        end
    end

    assign busy = full;
    assign take = start && !busy;

    ssnf_front #(
        .MAX_INTEGER_DIGITS  (MAX_INTEGER_DIGITS),
        .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS),
        .FRACTION_BITS       (FRACTION_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .reading       (reading),
        .reading_valid (reading_valid),
        .cfg_int       (int_digits_reg),
        .cfg_frac      (frac_digits_reg),
        .pop           (pop),
        .full          (full),
        .push          (push),
        .push_item     (push_item)
    );

    ssnf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .empty     (empty),
        .head      (head)
    );

    ssnf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .empty         (empty),
        .head          (head),
        .pop           (pop),
        .result_strobe (result_strobe),
        .segments      (segments),
        .point_after   (point_after),
        .cell_number   (cell_number),
        .overload      (overload),
        .last_cell     (last_cell)
    );

endmodule
